// ===== sv/kmst_pkg.sv =====
package kmst_pkg;

   localparam int MAX_VERTICES_DEFAULT = 16;
   localparam int MAX_EDGES_DEFAULT    = 64;

   localparam int VERTEX_W = 4;
   localparam int WEIGHT_W = 16;
   localparam int TOTAL_W  = 20;
   localparam int COUNT_W  = 4;
   localparam int CFG_W    = 5;
   localparam int KEY_W    = WEIGHT_W + 2 * VERTEX_W;

   // Fifteen tree edges at most.
   localparam logic [COUNT_W-1:0] MAX_TREE_EDGES = 4'd15;

   localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = 5'd16;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   localparam logic KIND_EDGE    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic                       op;
      logic [VERTEX_W-1:0]        src_vertex;
      logic [VERTEX_W-1:0]        dst_vertex;
      logic signed [WEIGHT_W-1:0] edge_weight;
   } req_type;

   typedef struct packed {
      logic                       kind;
      logic [VERTEX_W-1:0]        tree_src;
      logic [VERTEX_W-1:0]        tree_dst;
      logic signed [WEIGHT_W-1:0] tree_weight;
      logic signed [TOTAL_W-1:0]  total_weight;
      logic [COUNT_W-1:0]         edges_chosen;
      logic                       last;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;        // append request edge
      logic init;        // reset forest, sums, pointers
      logic sort_start;  // begin outer pass: read store[i], j <- i
      logic sort_read;   // read store[j-1]
      logic sort_step;   // compare/shift step
      logic walk_read;   // read store[i]
      logic find_step;   // one root chase step
      logic commit;      // link, accumulate, present edge beat
      logic skip;        // next edge
      logic summary;     // present summary beat
      logic clear;       // empty store
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic sort_done;    // outer index reached count
      logic shift_more;   // inner shift continues
      logic walk_done;    // no edges left
      logic roots_found;  // both chases settled
      logic joins;        // roots differ and room left
   } sts_type;

endpackage

// ===== sv/kruskal_mst_engine.sv =====
// Kruskal minimum spanning forest engine.
// req channel (valid/stall): op 0 loads one edge into the edge store; loads
// are taken one a cycle while req_stall is low. An edge naming a vertex not
// below vertex_count, or arriving with the store full, is dropped silently.
// op 1 runs: req_stall rises the cycle after the run beat and stays high
// until the summary beat is taken. The run insertion-sorts the store
// (per edge: read, key capture, wait, and compare steps until the key
// settles, over a one-read one-write edge memory), then walks it: per edge
// a read, a seed step, the root chase steps, and an emit step for a tree
// edge. The forest reset and the store clear are part of the run.
// rsp channel (valid/stall): one beat per tree edge, then a summary beat
// with last set. A beat is held in the output register while rsp_stall is
// high; the walk carries on to the next edge and waits only when another
// beat is ready.
// csr port: csr_write with csr_data sets vertex_count; write while idle.
// Reset (synchronous): store empty, vertex_count 16, no beat pending.
module kruskal_mst_engine #(
   parameter int MAX_VERTICES = kmst_pkg::MAX_VERTICES_DEFAULT,
   parameter int MAX_EDGES    = kmst_pkg::MAX_EDGES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  kmst_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output kmst_pkg::rsp_type          rsp_data,
   input  logic                       csr_write,
   input  logic [kmst_pkg::CFG_W-1:0] csr_data
);
   kmst_pkg::cmd_type cmd;
   kmst_pkg::sts_type sts;
   logic [kmst_pkg::CFG_W-1:0] vertex_count_ff;

   always_ff @(posedge clock) begin
      if (reset) vertex_count_ff <= kmst_pkg::VERTEX_COUNT_RESET;
      else if (csr_write) vertex_count_ff <= csr_data;
   end

   kmst_control u_control (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .cmd, .sts
   );

   kmst_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_datapath (
      .clock, .reset, .cmd, .sts, .req_data,
      .vertex_count(vertex_count_ff), .rsp_data
   );
endmodule

// ===== sv/kmst_datapath.sv =====
module kmst_datapath #(
   parameter int MAX_VERTICES = kmst_pkg::MAX_VERTICES_DEFAULT,
   parameter int MAX_EDGES    = kmst_pkg::MAX_EDGES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kmst_pkg::cmd_type             cmd,
   output kmst_pkg::sts_type             sts,
   input  kmst_pkg::req_type             req_data,
   input  logic [kmst_pkg::CFG_W-1:0]    vertex_count,
   output kmst_pkg::rsp_type             rsp_data
);
   localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int KW = kmst_pkg::KEY_W;

   logic [KW-1:0] store_mem [MAX_EDGES];
   logic [KW-1:0] rd_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [KW-1:0] key_ff, key_in;
   logic [VW-1:0] parent_ff [MAX_VERTICES];
   logic [VW-1:0] ru_ff, ru_in, rv_ff, rv_in;
   logic [kmst_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [kmst_pkg::COUNT_W-1:0] chosen_ff, chosen_in;
   kmst_pkg::rsp_type rsp_ff, rsp_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [KW-1:0] wr_data;
   logic          rd_en;
   logic          src_ok, dst_ok;
   logic [VW-1:0] pu, pv;
   logic [kmst_pkg::VERTEX_W-1:0] es, ed;
   logic [kmst_pkg::WEIGHT_W-1:0] ew;

   assign es = rd_ff[2*kmst_pkg::VERTEX_W-1:kmst_pkg::VERTEX_W];
   assign ed = rd_ff[kmst_pkg::VERTEX_W-1:0];
   assign ew = rd_ff[KW-1:2*kmst_pkg::VERTEX_W] ^ {1'b1, {(kmst_pkg::WEIGHT_W-1){1'b0}}};

   // Range tests: against vertex_count and the forest size.
   assign src_ok = ({1'b0, req_data.src_vertex} < vertex_count) &&
                   (32'(req_data.src_vertex) < MAX_VERTICES);
   assign dst_ok = ({1'b0, req_data.dst_vertex} < vertex_count) &&
                   (32'(req_data.dst_vertex) < MAX_VERTICES);

   assign pu = parent_ff[ru_ff];
   assign pv = parent_ff[rv_ff];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = {req_data.edge_weight ^ {1'b1, {(kmst_pkg::WEIGHT_W-1){1'b0}}},
                 req_data.src_vertex, req_data.dst_vertex};
      rd_en   = 1'b0;
      rd_addr = i_ff[AW-1:0];
      count_in = count_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      key_in   = key_ff;
      ru_in    = ru_ff;
      rv_in    = rv_ff;
      total_in = total_ff;
      chosen_in = chosen_ff;
      rsp_in   = rsp_ff;
      if (cmd.load) begin
         if (src_ok && dst_ok && (count_ff < CW'(MAX_EDGES))) begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.init) begin
         total_in  = '0;
         chosen_in = '0;
         i_in      = '0;
      end
      if (cmd.sort_start) begin
         // read store[i] for the key, j <- i
         rd_en = 1'b1;
         rd_addr = i_ff[AW-1:0];
         j_in = i_ff;
      end
      if (cmd.sort_read) begin
         key_in  = rd_ff;
         rd_en   = 1'b1;
         rd_addr = AW'(j_ff - 1'b1);
      end
      if (cmd.sort_step) begin
         if (sts.shift_more) begin
            wr_en   = 1'b1;
            wr_addr = j_ff[AW-1:0];
            wr_data = rd_ff;
            j_in    = j_ff - 1'b1;
            rd_en   = 1'b1;
            rd_addr = AW'(j_ff - 2'd2);
         end else begin
            wr_en   = 1'b1;
            wr_addr = j_ff[AW-1:0];
            wr_data = key_ff;
            i_in    = i_ff + 1'b1;
         end
      end
      if (cmd.walk_read) begin
         rd_en   = 1'b1;
         rd_addr = i_ff[AW-1:0];
      end
      if (cmd.find_step) begin
         ru_in = pu;
         rv_in = pv;
      end
      if (cmd.commit) begin
         total_in  = total_ff + kmst_pkg::TOTAL_W'($signed(ew));
         chosen_in = chosen_ff + 1'b1;
         rsp_in = '{kind: kmst_pkg::KIND_EDGE, tree_src: es, tree_dst: ed,
                    tree_weight: ew,
                    total_weight: total_ff + kmst_pkg::TOTAL_W'($signed(ew)),
                    edges_chosen: chosen_ff + 1'b1, last: 1'b0};
      end
      if (cmd.commit || cmd.skip) i_in = i_ff + 1'b1;
      if (cmd.summary) begin
         rsp_in = '{kind: kmst_pkg::KIND_SUMMARY, tree_src: '0, tree_dst: '0,
                    tree_weight: '0, total_weight: total_ff,
                    edges_chosen: chosen_ff, last: 1'b1};
      end
      if (cmd.clear) count_in = '0;
      // Hold the roots during the read; the seed path loads the edge ends.
      if (cmd.walk_read) begin
         ru_in = ru_ff;
         rv_in = rv_ff;
      end
   end

   // Root registers load the edge ends from the read register while seed_ff is high.
   logic seed_ff;

   always_ff @(posedge clock) begin
      if (wr_en) store_mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         seed_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         seed_ff   <= cmd.walk_read;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      key_ff    <= key_in;
      total_ff  <= total_in;
      chosen_ff <= chosen_in;
      rsp_ff    <= rsp_in;
      if (seed_ff) begin
         ru_ff <= VW'(es);
         rv_ff <= VW'(ed);
      end else begin
         ru_ff <= ru_in;
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_VERTICES; k++) begin
         if (cmd.init) parent_ff[k] <= VW'(k);
         else if (cmd.commit && (ru_ff == VW'(k))) parent_ff[k] <= rv_ff;
      end
   end

   always_comb begin
      sts.sort_done   = (i_ff >= count_ff);
      sts.shift_more  = (j_ff != '0) && (rd_ff > key_ff);
      sts.walk_done   = (i_ff >= count_ff);
      sts.roots_found = !seed_ff && (pu == ru_ff) && (pv == rv_ff);
      sts.joins       = (ru_ff != rv_ff) && (chosen_ff != kmst_pkg::MAX_TREE_EDGES);
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_EDGES)) else $error("edge count overflow");
   a_commit_roots: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (ru_ff != rv_ff)) else $error("link within one tree");
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (count_ff == '0)) else $error("store not emptied");
`endif
endmodule

// ===== sv/kmst_control.sv =====
module kmst_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  kmst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kmst_pkg::cmd_type cmd,
   input  kmst_pkg::sts_type sts
);
   typedef enum logic [9:0] {
      ST_IDLE    = 10'b0000000001,
      ST_SORT_TOP = 10'b0000000010,
      ST_SORT_KEY = 10'b0000000100,
      ST_SORT_CMP = 10'b0000001000,
      ST_WALK_TOP = 10'b0000010000,
      ST_WALK_SEED = 10'b0000100000,
      ST_FIND    = 10'b0001000000,
      ST_EMIT    = 10'b0010000000,
      ST_SUMMARY = 10'b0100000000,
      ST_SORT_WAIT = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      emit_ff, emit_in;
   logic      rsp_taken;

   assign rsp_taken = emit_ff && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      emit_in  = emit_ff && rsp_stall;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.op == kmst_pkg::OP_RUN) begin
                  cmd.init = 1'b1;
                  state_in = ST_SORT_TOP;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_SORT_TOP: begin
            // i starts at zero: first pass is a no-op insertion
            if (sts.sort_done) begin
               cmd.init = 1'b1;
               state_in = ST_WALK_TOP;
            end else begin
               cmd.sort_start = 1'b1;
               state_in = ST_SORT_KEY;
            end
         end
         ST_SORT_KEY: begin
            cmd.sort_read = 1'b1;
            state_in = ST_SORT_WAIT;
         end
         ST_SORT_WAIT: state_in = ST_SORT_CMP;
         ST_SORT_CMP: begin
            cmd.sort_step = 1'b1;
            if (!sts.shift_more) state_in = ST_SORT_TOP;
         end
         ST_WALK_TOP: begin
            if (sts.walk_done) begin
               if (!emit_ff || rsp_taken) begin
                  cmd.summary = 1'b1;
                  emit_in = 1'b1;
                  state_in = ST_SUMMARY;
               end
            end else begin
               cmd.walk_read = 1'b1;
               state_in = ST_WALK_SEED;
            end
         end
         ST_WALK_SEED: state_in = ST_FIND;
         ST_FIND: begin
            if (sts.roots_found) begin
               if (sts.joins) state_in = ST_EMIT;
               else begin
                  cmd.skip = 1'b1;
                  state_in = ST_WALK_TOP;
               end
            end else cmd.find_step = 1'b1;
         end
         ST_EMIT: begin
            if (!emit_ff || rsp_taken) begin
               cmd.commit = 1'b1;
               emit_in = 1'b1;
               state_in = ST_WALK_TOP;
            end
         end
         ST_SUMMARY: begin
            if (rsp_taken) begin
               cmd.clear = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy_in   = (state_in != ST_IDLE);
   assign req_stall = busy_ff;
   assign rsp_valid = emit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         emit_ff  <= emit_in;
      end
   end

`ifndef SYNTHESIS
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !busy_ff) else $error("idle but stalling");
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit || cmd.summary) |-> (!emit_ff || rsp_taken))
      else $error("result overwritten");
   a_summary_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUMMARY) |-> emit_ff) else $error("summary lost");
`endif
endmodule

// ===== bench/tb_kruskal_mst_engine.sv =====
module tb_kruskal_mst_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NV = kmst_pkg::MAX_VERTICES_DEFAULT;
   localparam int NE = kmst_pkg::MAX_EDGES_DEFAULT;
   localparam int VW = kmst_pkg::VERTEX_W;
   localparam int WW = kmst_pkg::WEIGHT_W;
   localparam int TW = kmst_pkg::TOTAL_W;
   localparam int KW = kmst_pkg::KEY_W;
   localparam int FW = kmst_pkg::CFG_W;
   localparam longint CYCLE_LIMIT = 2_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   kmst_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   kmst_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [FW-1:0] csr_data = '0;

   kruskal_mst_engine u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state: own copy of the store, count and vertex limit.
   logic [KW-1:0] edge_keys [NE];
   int unsigned   key_count;
   logic [FW-1:0] vtx_limit;

   kmst_pkg::req_type pending_beats [$];
   kmst_pkg::rsp_type expected_beats [$];
   int      error_count = 0;
   longint  cycle_count = 0;
   bit      quiet = 1'b0;   // no idling on either side while set

   function automatic int unsigned root_of(ref logic [VW-1:0] par [NV],
                                           input int unsigned v);
      int unsigned p;
      for (int k = 0; k < NV; k++) begin
         p = par[v];
         if (p == v) break;
         v = p;
      end
      return v;
   endfunction

   task automatic queue_req(input kmst_pkg::req_type r);
      pending_beats.insert(pending_beats.size(), r);
   endtask

   // Apply one accepted request to the predictor; a run queues its beats.
   task automatic predict_forest(input kmst_pkg::req_type r);
      logic [VW-1:0]           par [NV];
      logic [KW-1:0]           key;
      logic signed [TW-1:0]    total;
      logic [kmst_pkg::COUNT_W-1:0] chosen;
      int unsigned j, ru, rv;
      kmst_pkg::rsp_type b;
      if (r.op == kmst_pkg::OP_LOAD) begin
         if (r.src_vertex >= vtx_limit || r.dst_vertex >= vtx_limit) return;
         if (key_count >= NE) return;
         // bias the weight so unsigned key order is signed weight order
         edge_keys[key_count] = {r.edge_weight ^ 16'h8000, r.src_vertex, r.dst_vertex};
         key_count++;
         return;
      end
      for (int k = 0; k < NV; k++) par[k] = VW'(k);
      for (int unsigned i = 1; i < key_count; i++) begin
         key = edge_keys[i];
         j = i;
         while (j > 0 && edge_keys[j-1] > key) begin
            edge_keys[j] = edge_keys[j-1];
            j--;
         end
         edge_keys[j] = key;
      end
      total = '0;
      chosen = '0;
      for (int unsigned i = 0; i < key_count; i++) begin
         key = edge_keys[i];
         ru = root_of(par, key[2*VW-1:VW]);
         rv = root_of(par, key[VW-1:0]);
         if (ru == rv || chosen == kmst_pkg::MAX_TREE_EDGES) continue;
         par[ru] = VW'(rv);
         b = '0;
         b.kind = kmst_pkg::KIND_EDGE;
         b.tree_src = key[2*VW-1:VW];
         b.tree_dst = key[VW-1:0];
         b.tree_weight = key[KW-1:2*VW] ^ 16'h8000;
         total = total + TW'(b.tree_weight);
         chosen++;
         b.total_weight = total;
         b.edges_chosen = chosen;
         expected_beats.insert(expected_beats.size(), b);
      end
      b = '0;
      b.kind = kmst_pkg::KIND_SUMMARY;
      b.total_weight = total;
      b.edges_chosen = chosen;
      b.last = 1'b1;
      expected_beats.insert(expected_beats.size(), b);
      key_count = 0;
   endtask

   // Driver: present queued beats, idling about 29% unless quiet.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && !req_stall) predict_forest(req_data);
         if (!req_valid || !req_stall) begin
            if ((req_valid && !req_stall) || !req_valid) begin
               if (pending_beats.size() > 0 && (quiet || $urandom_range(99) >= 29)) begin
                  req_data <= pending_beats.pop_front();
                  req_valid <= 1'b1;
               end else begin
                  req_valid <= 1'b0;
               end
            end
         end
         rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 29);
      end
   end

   // Monitor: compare each taken result beat with the oldest expectation.
   always @(posedge clock) begin
      kmst_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected result beat %p", rsp_data);
            error_count++;
         end else begin
            e = expected_beats.pop_front();
            if (rsp_data.kind !== e.kind) begin
               $error("kind exp %0d got %0d", e.kind, rsp_data.kind); error_count++;
            end
            if (rsp_data.tree_src !== e.tree_src) begin
               $error("tree_src exp %0d got %0d", e.tree_src, rsp_data.tree_src);
               error_count++;
            end
            if (rsp_data.tree_dst !== e.tree_dst) begin
               $error("tree_dst exp %0d got %0d", e.tree_dst, rsp_data.tree_dst);
               error_count++;
            end
            if (rsp_data.tree_weight !== e.tree_weight) begin
               $error("tree_weight exp %0d got %0d", e.tree_weight, rsp_data.tree_weight);
               error_count++;
            end
            if (rsp_data.total_weight !== e.total_weight) begin
               $error("total_weight exp %0d got %0d", e.total_weight, rsp_data.total_weight);
               error_count++;
            end
            if (rsp_data.edges_chosen !== e.edges_chosen) begin
               $error("edges_chosen exp %0d got %0d", e.edges_chosen, rsp_data.edges_chosen);
               error_count++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_data.last); error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic kmst_pkg::req_type edge_beat(input int s, input int d, input int w);
      kmst_pkg::req_type r;
      r.op = kmst_pkg::OP_LOAD;
      r.src_vertex = VW'(s);
      r.dst_vertex = VW'(d);
      r.edge_weight = WW'(w);
      return r;
   endfunction

   function automatic kmst_pkg::req_type run_beat();
      kmst_pkg::req_type r;
      r = '0;
      r.op = kmst_pkg::OP_RUN;
      // junk in the unused fields of a run beat
      r.src_vertex = VW'($urandom);
      r.dst_vertex = VW'($urandom);
      r.edge_weight = WW'($urandom);
      return r;
   endfunction

   // Wait for every queued request and expected beat, then let the block settle to idle.
   task automatic drain();
      while (pending_beats.size() > 0 || req_valid || expected_beats.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_vertex_count(input int n);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_data <= FW'(n);
      @(posedge clock);
      csr_write <= 1'b0;
      vtx_limit = FW'(n);
   endtask

   // Random graph: mostly in-range edges, some out-of-range noise.
   task automatic random_graph(input int n_edges, input int nv);
      int s, d;
      for (int k = 0; k < n_edges; k++) begin
         if ($urandom_range(9) == 0) begin
            s = int'($urandom_range(15));
            d = int'($urandom_range(15));
         end else begin
            s = int'($urandom_range(nv - 1));
            d = int'($urandom_range(nv - 1));
         end
         queue_req(edge_beat(s, d, $urandom_range(3) == 0 ?
            int'($urandom) : int'($urandom_range(40)) - 20));
      end
      queue_req(run_beat());
   endtask

   initial begin
      int nv;
      key_count = 0;
      vtx_limit = kmst_pkg::VERTEX_COUNT_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty run, extremes, self loop, duplicates.
      queue_req(run_beat());
      queue_req(edge_beat(0, 15, -32768));
      queue_req(edge_beat(15, 0, 32767));
      queue_req(edge_beat(3, 3, -5));
      queue_req(edge_beat(1, 2, 7));
      queue_req(edge_beat(1, 2, 7));
      queue_req(edge_beat(2, 1, 7));
      queue_req(edge_beat(5, 15, 0));
      queue_req(run_beat());
      drain();

      set_vertex_count(1);
      queue_req(edge_beat(0, 0, 1));
      queue_req(edge_beat(0, 1, 1));
      queue_req(run_beat());
      drain();

      set_vertex_count(16);
      // chain reaching the tree-edge limit
      for (int k = 0; k < 15; k++) queue_req(edge_beat(k, k + 1, -1000 * k));
      queue_req(edge_beat(0, 15, 32767));
      queue_req(run_beat());
      drain();

      set_vertex_count(4);
      queue_req(edge_beat(4, 0, 9));
      queue_req(edge_beat(0, 3, 9));
      queue_req(run_beat());
      drain();

      // Store overflow: more than 64 loads before a run.
      set_vertex_count(16);
      random_graph(70, 16);
      drain();

      // Random phases with varying vertex counts; first one without idling.
      for (int ph = 0; ph < 6; ph++) begin
         quiet = (ph == 0);
         nv = (ph % 3 == 0) ? 16 : int'($urandom_range(2, 16));
         set_vertex_count(nv);
         for (int g = 0; g < 4; g++) random_graph(int'($urandom_range(0, 10)), nv);
         drain();
      end
      quiet = 1'b0;
      set_vertex_count(16);

      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
